// File: sv/chol_pkg.sv
// Shared types, constants and arithmetic helpers of the Cholesky update block.
`default_nettype none
package chol_pkg;

  localparam int DIM_DEF = 16;
  localparam int DATA_W  = 32;
  localparam int ROW_W   = 6;
  localparam int OP_W    = 2;
  localparam int ST_W    = 2;
  localparam int IDX_W   = 7;
  localparam int ACC_W   = 49;
  localparam int PQ_W    = 48;
  localparam int UOP_W   = 5;

  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

  // Operation codes of an input item.
  localparam logic [OP_W-1:0] OP_LOAD_F = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_X = 2'd1;
  localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;
  localparam logic [OP_W-1:0] OP_READ   = 2'd3;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_NEG_RAD  = 2'd1;
  localparam logic [ST_W-1:0] ST_ZERO_PIV = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE    = 2'd3;

  // Datapath micro-operations issued by the controller.
  localparam logic [UOP_W-1:0] U_NOP    = 5'd0;
  localparam logic [UOP_W-1:0] U_ACCEPT = 5'd1;
  localparam logic [UOP_W-1:0] U_RDCAP  = 5'd2;
  localparam logic [UOP_W-1:0] U_PRD    = 5'd3;
  localparam logic [UOP_W-1:0] U_PLAT   = 5'd4;
  localparam logic [UOP_W-1:0] U_MWX    = 5'd5;
  localparam logic [UOP_W-1:0] U_MRR    = 5'd6;
  localparam logic [UOP_W-1:0] U_MWXX   = 5'd7;
  localparam logic [UOP_W-1:0] U_RAD    = 5'd8;
  localparam logic [UOP_W-1:0] U_FAIL1  = 5'd9;
  localparam logic [UOP_W-1:0] U_FAIL2  = 5'd10;
  localparam logic [UOP_W-1:0] U_SQ     = 5'd11;
  localparam logic [UOP_W-1:0] U_R      = 5'd12;
  localparam logic [UOP_W-1:0] U_C      = 5'd13;
  localparam logic [UOP_W-1:0] U_S      = 5'd14;
  localparam logic [UOP_W-1:0] U_WS     = 5'd15;
  localparam logic [UOP_W-1:0] U_JRD    = 5'd16;
  localparam logic [UOP_W-1:0] U_JLAT   = 5'd17;
  localparam logic [UOP_W-1:0] U_JM1    = 5'd18;
  localparam logic [UOP_W-1:0] U_JNUM   = 5'd19;
  localparam logic [UOP_W-1:0] U_JDIV   = 5'd20;
  localparam logic [UOP_W-1:0] U_JQ     = 5'd21;
  localparam logic [UOP_W-1:0] U_JM3    = 5'd22;
  localparam logic [UOP_W-1:0] U_JM4    = 5'd23;
  localparam logic [UOP_W-1:0] U_JWR    = 5'd24;
  localparam logic [UOP_W-1:0] U_OK     = 5'd25;
  localparam logic [UOP_W-1:0] U_PUSH   = 5'd26;

  typedef struct packed {
    logic [UOP_W-1:0] uop;
    logic [IDX_W-1:0] k;
    logic [IDX_W-1:0] j;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            idx_ok;
    logic            rad_neg;
    logic            piv_zero;
    logic            unit_busy;
  } sts_t;

  // Q16.16 product scaled back, rounding toward minus infinity, sign-extended.
  function automatic logic signed [ACC_W-1:0] ext_q(input logic signed [63:0] p);
    return {p[63], p[63:16]};
  endfunction

  function automatic logic signed [ACC_W-1:0] ext32(input logic signed [DATA_W-1:0] v);
    return {{(ACC_W-DATA_W){v[DATA_W-1]}}, v};
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic ovf;
    ovf = (v[ACC_W-1:DATA_W-1] != {(ACC_W-DATA_W+1){v[ACC_W-1]}});
    if (ovf) begin
      return v[ACC_W-1] ? Q_MIN : Q_MAX;
    end
    return v[DATA_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: sv/chol_if.sv
// Handshake interfaces of the item and result channels.
`default_nettype none
interface chol_item_if;
  logic                              valid;
  logic                              ready;
  logic [chol_pkg::OP_W-1:0]         operation;
  logic [chol_pkg::ROW_W-1:0]        row;
  logic [chol_pkg::ROW_W-1:0]        col;
  logic signed [chol_pkg::DATA_W-1:0] value;
  logic signed [chol_pkg::DATA_W-1:0] weight;

  modport source(output valid, operation, row, col, value, weight, input ready);
  modport sink(input valid, operation, row, col, value, weight, output ready);
endinterface

interface chol_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [chol_pkg::DATA_W-1:0] read_value;
  logic [chol_pkg::ST_W-1:0]         status;

  modport source(output valid, read_value, status, input ready);
  modport sink(input valid, read_value, status, output ready);
endinterface
`default_nettype wire

// File: sv/chol_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module chol_ram #(
  parameter int WIDTH = chol_pkg::DATA_W,
  parameter int DEPTH = chol_pkg::DIM_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: sv/chol_unit.sv
// Shared iterative unit: Q16.16 division and integer square root, one bit per cycle.
`default_nettype none
module chol_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic                                 sq_mode,
  input  logic signed [chol_pkg::ACC_W-1:0]    num,
  input  logic signed [chol_pkg::DATA_W-1:0]   den,
  output logic signed [chol_pkg::DATA_W-1:0]   res,
  output logic                                 busy
);
  localparam logic [1:0] MODE_DIV  = 2'd0;
  localparam logic [1:0] MODE_SQRT = 2'd1;
  localparam logic [1:0] MODE_FIX  = 2'd2;
  localparam logic [5:0] DIV_STEPS  = 6'd31;
  localparam logic [5:0] SQRT_STEPS = 6'd32;
  localparam logic signed [chol_pkg::ACC_W-1:0] NUM_LIM = chol_pkg::ACC_W'(1) << 47;

  logic [1:0]  mode;
  logic [5:0]  cnt;
  logic        neg;
  logic [31:0] dd;
  logic [31:0] drem;
  logic [30:0] dvd;
  logic [30:0] dq;
  logic [63:0] sv;
  logic [32:0] srem;
  logic [31:0] sres;

  logic signed [chol_pkg::ACC_W-1:0] num_c;
  logic [chol_pkg::PQ_W-1:0] mag;
  logic [31:0] dmag;
  logic [63:0] nn;
  logic        ovf;
  logic        neg_c;
  logic [32:0] dt;
  logic [34:0] st;
  logic [34:0] strial;

  always_comb begin
    if (num > NUM_LIM) begin
      num_c = NUM_LIM;
    end else if (num < -NUM_LIM) begin
      num_c = -NUM_LIM;
    end else begin
      num_c = num;
    end
    mag    = chol_pkg::PQ_W'(num_c[chol_pkg::ACC_W-1] ? -num_c : num_c);
    dmag   = den[31] ? ($unsigned(~den) + 32'd1) : $unsigned(den);
    nn     = {mag, 16'b0};
    ovf    = (nn >= {1'b0, dmag, 31'b0});
    neg_c  = num_c[chol_pkg::ACC_W-1] ^ den[31];
    dt     = {drem, dvd[30]};
    st     = {srem, sv[63:62]};
    strial = {1'b0, sres, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      if (sq_mode) begin
        cnt <= SQRT_STEPS;
      end else if (dmag == 32'd0 || ovf) begin
        cnt <= '0;
      end else begin
        cnt <= DIV_STEPS;
      end
    end else if (busy) begin
      if (cnt == 6'd0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      if (sq_mode) begin
        mode <= MODE_SQRT;
        sv   <= {num[47:0], 16'b0};
        srem <= '0;
        sres <= '0;
      end else if (dmag == 32'd0) begin
        // Zero divisor: saturate toward the sign of the numerator.
        mode <= MODE_FIX;
        if (num_c > 0) begin
          res <= chol_pkg::Q_MAX;
        end else if (num_c < 0) begin
          res <= chol_pkg::Q_MIN;
        end else begin
          res <= '0;
        end
      end else if (ovf) begin
        mode <= MODE_FIX;
        res  <= neg_c ? chol_pkg::Q_MIN : chol_pkg::Q_MAX;
      end else begin
        mode <= MODE_DIV;
        neg  <= neg_c;
        dd   <= dmag;
        drem <= nn[62:31];
        dvd  <= nn[30:0];
        dq   <= '0;
      end
    end else if (busy) begin
      if (cnt == 6'd0) begin
        if (mode == MODE_DIV) begin
          res <= neg ? -$signed({1'b0, dq}) : $signed({1'b0, dq});
        end else if (mode == MODE_SQRT) begin
          res <= sres[31] ? chol_pkg::Q_MAX : $signed(sres);
        end
      end else if (mode == MODE_DIV) begin
        if (dt >= {1'b0, dd}) begin
          drem <= 32'(dt - {1'b0, dd});
          dq   <= {dq[29:0], 1'b1};
        end else begin
          drem <= dt[31:0];
          dq   <= {dq[29:0], 1'b0};
        end
        dvd <= {dvd[29:0], 1'b0};
      end else if (mode == MODE_SQRT) begin
        if (st >= strial) begin
          srem <= 33'(st - strial);
          sres <= {sres[30:0], 1'b1};
        end else begin
          srem <= st[32:0];
          sres <= {sres[30:0], 1'b0};
        end
        sv <= {sv[61:0], 2'b00};
      end
    end
  end
endmodule
`default_nettype wire

// File: sv/chol_ctrl.sv
// Controller state machine that sequences loads, reads and the pivot loop.
`default_nettype none
module chol_ctrl #(
  parameter int DIM = chol_pkg::DIM_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  chol_pkg::sts_t  sts,
  output chol_pkg::cmd_t  cmd
);
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_RDCAP = 5'd1;
  localparam logic [4:0] S_PRD   = 5'd2;
  localparam logic [4:0] S_PLAT  = 5'd3;
  localparam logic [4:0] S_MWX   = 5'd4;
  localparam logic [4:0] S_MRR   = 5'd5;
  localparam logic [4:0] S_MWXX  = 5'd6;
  localparam logic [4:0] S_RAD   = 5'd7;
  localparam logic [4:0] S_CHK   = 5'd8;
  localparam logic [4:0] S_WSQ   = 5'd9;
  localparam logic [4:0] S_WC    = 5'd10;
  localparam logic [4:0] S_WS    = 5'd11;
  localparam logic [4:0] S_WSW   = 5'd12;
  localparam logic [4:0] S_JRD   = 5'd13;
  localparam logic [4:0] S_JLAT  = 5'd14;
  localparam logic [4:0] S_JM1   = 5'd15;
  localparam logic [4:0] S_JNUM  = 5'd16;
  localparam logic [4:0] S_JDIV  = 5'd17;
  localparam logic [4:0] S_WQ    = 5'd18;
  localparam logic [4:0] S_JM3   = 5'd19;
  localparam logic [4:0] S_JM4   = 5'd20;
  localparam logic [4:0] S_JWR   = 5'd21;
  localparam logic [4:0] S_FIN   = 5'd22;
  localparam logic [4:0] S_DONE  = 5'd23;

  localparam logic [chol_pkg::IDX_W-1:0] DIM_I = chol_pkg::IDX_W'(DIM);
  localparam logic [chol_pkg::IDX_W-1:0] ONE_I = chol_pkg::IDX_W'(1);

  logic [4:0] state;
  logic [4:0] state_next;
  logic [chol_pkg::IDX_W-1:0] k;
  logic [chol_pkg::IDX_W-1:0] k_next;
  logic [chol_pkg::IDX_W-1:0] j;
  logic [chol_pkg::IDX_W-1:0] j_next;
  logic [chol_pkg::UOP_W-1:0] uop;
  logic accept;
  logic push;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign push     = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    k_next     = k;
    j_next     = j;
    uop        = chol_pkg::U_NOP;
    case (state)
      S_IDLE: begin
        if (accept) begin
          uop = chol_pkg::U_ACCEPT;
          if (sts.op == chol_pkg::OP_UPDATE) begin
            k_next     = '0;
            state_next = S_PRD;
          end else if (sts.op == chol_pkg::OP_READ && sts.idx_ok) begin
            state_next = S_RDCAP;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_RDCAP: begin
        uop        = chol_pkg::U_RDCAP;
        state_next = S_DONE;
      end
      S_PRD: begin
        uop        = chol_pkg::U_PRD;
        state_next = S_PLAT;
      end
      S_PLAT: begin
        uop        = chol_pkg::U_PLAT;
        state_next = S_MWX;
      end
      S_MWX: begin
        uop        = chol_pkg::U_MWX;
        state_next = S_MRR;
      end
      S_MRR: begin
        uop        = chol_pkg::U_MRR;
        state_next = S_MWXX;
      end
      S_MWXX: begin
        uop        = chol_pkg::U_MWXX;
        state_next = S_RAD;
      end
      S_RAD: begin
        uop        = chol_pkg::U_RAD;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (sts.rad_neg) begin
          uop        = chol_pkg::U_FAIL1;
          state_next = S_DONE;
        end else if (sts.piv_zero) begin
          uop        = chol_pkg::U_FAIL2;
          state_next = S_DONE;
        end else begin
          uop        = chol_pkg::U_SQ;
          state_next = S_WSQ;
        end
      end
      S_WSQ: begin
        if (!sts.unit_busy) begin
          uop        = chol_pkg::U_R;
          state_next = S_WC;
        end
      end
      S_WC: begin
        if (!sts.unit_busy) begin
          uop        = chol_pkg::U_C;
          state_next = S_WS;
        end
      end
      S_WS: begin
        if (!sts.unit_busy) begin
          uop        = chol_pkg::U_S;
          state_next = S_WSW;
        end
      end
      S_WSW: begin
        uop = chol_pkg::U_WS;
        if (k + ONE_I == DIM_I) begin
          state_next = S_FIN;
        end else begin
          j_next     = k + ONE_I;
          state_next = S_JRD;
        end
      end
      S_JRD: begin
        uop        = chol_pkg::U_JRD;
        state_next = S_JLAT;
      end
      S_JLAT: begin
        uop        = chol_pkg::U_JLAT;
        state_next = S_JM1;
      end
      S_JM1: begin
        uop        = chol_pkg::U_JM1;
        state_next = S_JNUM;
      end
      S_JNUM: begin
        uop        = chol_pkg::U_JNUM;
        state_next = S_JDIV;
      end
      S_JDIV: begin
        uop        = chol_pkg::U_JDIV;
        state_next = S_WQ;
      end
      S_WQ: begin
        if (!sts.unit_busy) begin
          uop        = chol_pkg::U_JQ;
          state_next = S_JM3;
        end
      end
      S_JM3: begin
        uop        = chol_pkg::U_JM3;
        state_next = S_JM4;
      end
      S_JM4: begin
        uop        = chol_pkg::U_JM4;
        state_next = S_JWR;
      end
      S_JWR: begin
        uop = chol_pkg::U_JWR;
        if (j + ONE_I == DIM_I) begin
          k_next = k + ONE_I;
          if (k + ONE_I == DIM_I) begin
            state_next = S_FIN;
          end else begin
            state_next = S_PRD;
          end
        end else begin
          j_next     = j + ONE_I;
          state_next = S_JRD;
        end
      end
      S_FIN: begin
        uop        = chol_pkg::U_OK;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (push) begin
          uop        = chol_pkg::U_PUSH;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      k         <= '0;
      j         <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      k     <= k_next;
      j     <= j_next;
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign cmd.uop = uop;
  assign cmd.k   = k;
  assign cmd.j   = j;
endmodule
`default_nettype wire

// File: sv/chol_dp.sv
// Datapath: factor and vector memories, shared multiplier, divide/sqrt unit, result register.
`default_nettype none
module chol_dp #(
  parameter int DIM = chol_pkg::DIM_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [chol_pkg::OP_W-1:0]           operation,
  input  logic [chol_pkg::ROW_W-1:0]          row,
  input  logic [chol_pkg::ROW_W-1:0]          col,
  input  logic signed [chol_pkg::DATA_W-1:0]  value,
  input  logic signed [chol_pkg::DATA_W-1:0]  weight,
  input  chol_pkg::cmd_t                      cmd,
  output chol_pkg::sts_t                      sts,
  output logic signed [chol_pkg::DATA_W-1:0]  read_value,
  output logic [chol_pkg::ST_W-1:0]           status
);
  localparam int FDEPTH = DIM * DIM;
  localparam int FAW    = $clog2(FDEPTH);
  localparam int VAW    = $clog2(DIM);
  localparam logic [chol_pkg::IDX_W-1:0] DIM_I = chol_pkg::IDX_W'(DIM);

  logic signed [chol_pkg::DATA_W-1:0] w, rkk, xk, wx, c, s, ws, rold, xj, rkj;
  logic signed [chol_pkg::ACC_W-1:0]  acc;
  logic signed [63:0]                 pr;
  logic signed [chol_pkg::ACC_W-1:0]  q;
  logic signed [chol_pkg::DATA_W-1:0] res_val;
  logic [chol_pkg::ST_W-1:0]          res_status;

  logic row_ok, col_ok, idx_ok;
  logic [FAW-1:0] in_faddr, kk_addr, kj_addr;

  logic            f_we;
  logic [FAW-1:0]  f_waddr, f_raddr;
  logic [chol_pkg::DATA_W-1:0] f_wdata, f_rdata;
  logic            v_we, wk_we;
  logic [VAW-1:0]  x_raddr;
  logic [chol_pkg::DATA_W-1:0] v_rdata, wk_rdata;
  logic signed [chol_pkg::DATA_W-1:0] x_dout;

  logic signed [chol_pkg::DATA_W-1:0] mul_a, mul_b;
  logic                               u_start, u_sq, u_busy;
  logic signed [chol_pkg::ACC_W-1:0]  u_num;
  logic signed [chol_pkg::DATA_W-1:0] u_den, u_res;

  assign row_ok   = chol_pkg::IDX_W'(row) < DIM_I;
  assign col_ok   = chol_pkg::IDX_W'(col) < DIM_I;
  assign idx_ok   = (operation == chol_pkg::OP_LOAD_X) ? row_ok : (row_ok && col_ok);
  assign in_faddr = FAW'(int'(row) * DIM + int'(col));
  assign kk_addr  = FAW'(int'(cmd.k) * DIM + int'(cmd.k));
  assign kj_addr  = FAW'(int'(cmd.k) * DIM + int'(cmd.j));
  assign q        = chol_pkg::ext_q(pr);
  assign x_dout   = (cmd.k == '0) ? $signed(v_rdata) : $signed(wk_rdata);

  always_comb begin
    sts.op        = operation;
    sts.idx_ok    = idx_ok;
    sts.rad_neg   = acc[chol_pkg::ACC_W-1];
    sts.piv_zero  = (rkk == '0);
    sts.unit_busy = u_busy;
  end

  // Memory port selection.
  always_comb begin
    f_we    = 1'b0;
    f_waddr = in_faddr;
    f_wdata = value;
    f_raddr = in_faddr;
    x_raddr = cmd.j[VAW-1:0];
    case (cmd.uop)
      chol_pkg::U_ACCEPT: begin
        f_we = (operation == chol_pkg::OP_LOAD_F) && idx_ok;
      end
      chol_pkg::U_PRD: begin
        f_raddr = kk_addr;
        x_raddr = cmd.k[VAW-1:0];
      end
      chol_pkg::U_R: begin
        f_we    = 1'b1;
        f_waddr = kk_addr;
        f_wdata = u_res;
      end
      chol_pkg::U_JRD: begin
        f_raddr = kj_addr;
      end
      chol_pkg::U_JQ: begin
        f_we    = 1'b1;
        f_waddr = kj_addr;
        f_wdata = u_res;
      end
      default: begin
      end
    endcase
  end

  assign v_we  = (cmd.uop == chol_pkg::U_ACCEPT) && (operation == chol_pkg::OP_LOAD_X) && idx_ok;
  assign wk_we = (cmd.uop == chol_pkg::U_JWR);

  chol_ram #(.WIDTH(chol_pkg::DATA_W), .DEPTH(FDEPTH)) u_factor_ram (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_rdata)
  );

  chol_ram #(.WIDTH(chol_pkg::DATA_W), .DEPTH(DIM)) u_vec_ram (
    .clk(clk), .we(v_we), .waddr(row[VAW-1:0]), .wdata(value),
    .raddr(x_raddr), .rdata(v_rdata)
  );

  chol_ram #(.WIDTH(chol_pkg::DATA_W), .DEPTH(DIM)) u_work_ram (
    .clk(clk), .we(wk_we), .waddr(cmd.j[VAW-1:0]), .wdata(chol_pkg::sat32(acc)),
    .raddr(x_raddr), .rdata(wk_rdata)
  );

  // Multiplier operand selection.
  always_comb begin
    mul_a = w;
    mul_b = xk;
    case (cmd.uop)
      chol_pkg::U_MRR: begin
        mul_a = rkk;
        mul_b = rkk;
      end
      chol_pkg::U_MWXX: begin
        mul_a = wx;
        mul_b = xk;
      end
      chol_pkg::U_S: begin
        mul_a = w;
        mul_b = u_res;
      end
      chol_pkg::U_JM1: begin
        mul_a = ws;
        mul_b = xj;
      end
      chol_pkg::U_JQ: begin
        mul_a = c;
        mul_b = xj;
      end
      chol_pkg::U_JM3: begin
        mul_a = s;
        mul_b = rkj;
      end
      default: begin
      end
    endcase
  end

  // Divide and square-root requests.
  always_comb begin
    u_start = 1'b0;
    u_sq    = 1'b0;
    u_num   = acc;
    u_den   = rkk;
    case (cmd.uop)
      chol_pkg::U_SQ: begin
        u_start = 1'b1;
        u_sq    = 1'b1;
      end
      chol_pkg::U_R: begin
        u_start = 1'b1;
        u_num   = chol_pkg::ext32(u_res);
      end
      chol_pkg::U_C: begin
        u_start = 1'b1;
        u_num   = chol_pkg::ext32(xk);
      end
      chol_pkg::U_JDIV: begin
        u_start = 1'b1;
        u_den   = c;
      end
      default: begin
      end
    endcase
  end

  chol_unit u_unit (
    .clk(clk), .rst(rst), .start(u_start), .sq_mode(u_sq),
    .num(u_num), .den(u_den), .res(u_res), .busy(u_busy)
  );

  always_ff @(posedge clk) begin
    pr <= mul_a * mul_b;
    case (cmd.uop)
      chol_pkg::U_ACCEPT: begin
        w          <= weight;
        res_val    <= '0;
        res_status <= (operation != chol_pkg::OP_UPDATE && !idx_ok) ?
                      chol_pkg::ST_RANGE : chol_pkg::ST_OK;
      end
      chol_pkg::U_RDCAP: res_val <= f_rdata;
      chol_pkg::U_PLAT: begin
        rkk <= f_rdata;
        xk  <= x_dout;
      end
      chol_pkg::U_MRR:   wx  <= chol_pkg::sat32(q);
      chol_pkg::U_MWXX:  acc <= q;
      chol_pkg::U_RAD:   acc <= acc + q;
      chol_pkg::U_FAIL1: res_status <= chol_pkg::ST_NEG_RAD;
      chol_pkg::U_FAIL2: res_status <= chol_pkg::ST_ZERO_PIV;
      chol_pkg::U_C:     c  <= u_res;
      chol_pkg::U_S:     s  <= u_res;
      chol_pkg::U_WS:    ws <= chol_pkg::sat32(q);
      chol_pkg::U_JLAT: begin
        rold <= f_rdata;
        xj   <= x_dout;
      end
      chol_pkg::U_JNUM:  acc <= chol_pkg::ext32(rold) + q;
      chol_pkg::U_JQ:    rkj <= u_res;
      chol_pkg::U_JM3:   acc <= q;
      chol_pkg::U_JM4:   acc <= acc - q;
      chol_pkg::U_OK:    res_status <= chol_pkg::ST_OK;
      chol_pkg::U_PUSH: begin
        read_value <= res_val;
        status     <= res_status;
      end
      default: begin
      end
    endcase
  end
endmodule
`default_nettype wire

// File: sv/cholesky_weighted_rank_one_update.sv
// Top level of the weighted rank-one Cholesky update and downdate block.
//
//   Channel  | Direction | Payload
//   ---------+-----------+------------------------------------------------
//   item     | in        | operation, row, col, value, weight
//   result   | out       | read_value, status (one result per item)
//
// An update steps through the pivots in turn and stops early when one fails
// its check; the shared divide/square-root unit, which resolves one quotient
// or root bit per cycle, takes up most of the time of an update.
// Reset is synchronous and active high; the memories are not cleared.
// One item is worked on at a time; a finished result waits in the output
// register while the next item is taken, and a full output register stalls
// only the delivery step of that next item.
`default_nettype none
module cholesky_weighted_rank_one_update #(
  parameter int DIM = chol_pkg::DIM_DEF
) (
  input  logic          clk,
  input  logic          rst,
  chol_item_if.sink     item,
  chol_result_if.source result
);
  chol_pkg::cmd_t cmd;
  chol_pkg::sts_t sts;

  // The controller owns the handshakes and sequences the pivot loop.
  chol_ctrl #(.DIM(DIM)) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(item.valid),
    .in_ready(item.ready),
    .out_valid(result.valid),
    .out_ready(result.ready),
    .sts(sts),
    .cmd(cmd)
  );

  // The datapath holds the factor, the vectors and all arithmetic.
  chol_dp #(.DIM(DIM)) u_dp (
    .clk(clk),
    .rst(rst),
    .operation(item.operation),
    .row(item.row),
    .col(item.col),
    .value(item.value),
    .weight(item.weight),
    .cmd(cmd),
    .sts(sts),
    .read_value(result.read_value),
    .status(result.status)
  );
endmodule
`default_nettype wire

// File: sv/chol_checker.sv
// Port-level assertions of the Cholesky update block and their binding.
`default_nettype none
module chol_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [chol_pkg::DATA_W-1:0] read_value,
  input logic [chol_pkg::ST_W-1:0]   status
);
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != chol_pkg::ST_OK |-> read_value == '0)
    else $error("nonzero value with error status");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while another is in work");
endmodule

bind cholesky_weighted_rank_one_update chol_checker u_chol_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(item.valid),
  .in_ready(item.ready),
  .out_valid(result.valid),
  .out_ready(result.ready),
  .read_value(result.read_value),
  .status(result.status)
);
`default_nettype wire

// File: tb/sv/chol_update_checker.sv
`timescale 1ns / 100ps
// Transfer monitor, factor-update predictor and result scoreboard of the Cholesky update block.
module chol_update_checker #(
  parameter int DIM = chol_pkg::DIM_DEF
) (
  input  logic   clk,
  input  logic   rst,
  chol_item_if   item,
  chol_result_if result,
  output int     failures,
  output int     pending
);
  import chol_pkg::*;

  typedef struct {
    logic signed [DATA_W-1:0] read_value;
    logic [ST_W-1:0]          status;
  } answer_t;

  longint   factor_q [DIM][DIM];
  longint   vector_q [DIM];
  answer_t  answers_due [$];

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;
  localparam longint NUM_CAP = 64'sd1 << 47;

  function automatic longint clamp32(input longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  // Exact product scaled back by 2^16, rounded toward minus infinity.
  function automatic longint qprod(input longint a, input longint b);
    longint p;
    p = a * b;
    return p >>> 16;
  endfunction

  // Quotient rounded toward zero; a zero divisor saturates toward the numerator's sign.
  function automatic longint qquot(input longint num, input longint den);
    longint unsigned un, ud, q;
    logic neg;
    if (num > NUM_CAP) num = NUM_CAP;
    if (num < -NUM_CAP) num = -NUM_CAP;
    if (den == 0) begin
      if (num > 0) return SAT_HI;
      if (num < 0) return SAT_LO;
      return 0;
    end
    neg = (num < 0) != (den < 0);
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    q = (un << 16) / ud;
    if (q > (64'd1 << 32)) q = 64'd1 << 32;
    return clamp32(neg ? -longint'(q) : longint'(q));
  endfunction

  function automatic longint unsigned int_root(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Applies R'R + w*x*x' pivot by pivot; returns the status of the update.
  function automatic logic [ST_W-1:0] rotate_factor(input longint w);
    longint xw [DIM];
    longint rkk, xk, wx, rad, r, c, s, ws, xj, rkj;
    for (int i = 0; i < DIM; i++) xw[i] = vector_q[i];
    for (int k = 0; k < DIM; k++) begin
      rkk = factor_q[k][k];
      xk = xw[k];
      wx = clamp32(qprod(w, xk));
      rad = qprod(rkk, rkk) + qprod(wx, xk);
      if (rad < 0) return ST_NEG_RAD;
      if (rkk == 0) return ST_ZERO_PIV;
      r = clamp32(longint'(int_root(longint'(rad) << 16)));
      c = qquot(r, rkk);
      s = qquot(xk, rkk);
      factor_q[k][k] = r;
      ws = clamp32(qprod(w, s));
      for (int j = k + 1; j < DIM; j++) begin
        xj = xw[j];
        rkj = qquot(factor_q[k][j] + qprod(ws, xj), c);
        factor_q[k][j] = rkj;
        xw[j] = clamp32(qprod(c, xj) - qprod(s, rkj));
      end
    end
    return ST_OK;
  endfunction

  assign pending = answers_due.size();

  initial failures = 0;

  always @(posedge clk) begin
    answer_t a, e;
    if (!rst && item.valid && item.ready) begin
      a.read_value = '0;
      a.status = ST_OK;
      case (item.operation)
        OP_LOAD_F: begin
          if (item.row < DIM && item.col < DIM)
            factor_q[item.row][item.col] = longint'(item.value);
          else a.status = ST_RANGE;
        end
        OP_LOAD_X: begin
          if (item.row < DIM) vector_q[item.row] = longint'(item.value);
          else a.status = ST_RANGE;
        end
        OP_UPDATE: a.status = rotate_factor(longint'(item.weight));
        default: begin
          if (item.row < DIM && item.col < DIM)
            a.read_value = DATA_W'(factor_q[item.row][item.col]);
          else a.status = ST_RANGE;
        end
      endcase
      answers_due.insert(answers_due.size(), a);
    end
    if (!rst && result.valid && result.ready) begin
      if (answers_due.size() == 0) begin
        failures++;
        $display("%0t: unexpected result read_value=%0d status=%0d", $time,
                 result.read_value, result.status);
      end else begin
        e = answers_due.pop_front();
        if (result.read_value !== e.read_value) begin
          failures++;
          $display("%0t: read_value expected %0d actual %0d", $time, e.read_value,
                   result.read_value);
        end
        if (result.status !== e.status) begin
          failures++;
          $display("%0t: status expected %0d actual %0d", $time, e.status, result.status);
        end
      end
    end
  end
endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Top of the Cholesky update testbench: clock, reset, item stimulus and verdict.
module tb;
  import chol_pkg::*;

  localparam int DIM = DIM_DEF;
  localparam int ITEM_GOAL = 600;
  // The limit covers a full update over all pivots; a stalled receiver adds little.
  localparam int STALL_LIMIT = 60000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   failures, pending;
  int   sent = 0;
  int   quiet_cycles = 0;
  logic idle_on = 1'b1;

  chol_item_if   item ();
  chol_result_if result ();

  cholesky_weighted_rank_one_update #(.DIM(DIM)) dut (
    .clk(clk), .rst(rst), .item(item), .result(result)
  );

  chol_update_checker #(.DIM(DIM)) checker_i (
    .clk(clk), .rst(rst), .item(item), .result(result),
    .failures(failures), .pending(pending)
  );

  always #2 clk = ~clk;

  // The receiver stalls at random, except during the quiet stretch.
  always @(negedge clk) begin
    result.ready <= idle_on ? ($urandom_range(99) >= 21) : 1'b1;
  end

  // The watchdog ends a run in which no transfer happens for too long.
  always @(posedge clk) begin
    if ((item.valid && item.ready) || (result.valid && result.ready)) begin
      quiet_cycles <= 0;
    end else if (!rst) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // Sends one item; a random gap with valid low may come first.
  task automatic put(input logic [OP_W-1:0] op, input int r, input int c,
                     input logic signed [DATA_W-1:0] v, input logic signed [DATA_W-1:0] w);
    int gap;
    gap = (idle_on && $urandom_range(99) < 21) ? $urandom_range(3, 1) : 0;
    @(negedge clk);
    if (gap > 0) begin
      item.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item.valid     <= 1'b1;
    item.operation <= op;
    item.row       <= r[ROW_W-1:0];
    item.col       <= c[ROW_W-1:0];
    item.value     <= v;
    item.weight    <= w;
    do @(posedge clk); while (!item.ready);
    sent++;
    idle_on = !(sent >= 250 && sent < 360);
  endtask

  // A data value: mostly small magnitudes, sometimes anything or an extreme.
  function automatic logic signed [DATA_W-1:0] any_value();
    int pick;
    pick = $urandom_range(99);
    if (pick < 5) return Q_MAX;
    if (pick < 10) return Q_MIN;
    if (pick < 22) return $urandom();
    return $signed($urandom_range(524288)) - 262144;
  endfunction

  function automatic logic signed [DATA_W-1:0] pivot_value();
    return $urandom_range(400000, 16384);
  endfunction

  initial begin
    int kind, n, k;
    item.valid = 1'b0;
    item.operation = OP_LOAD_F;
    item.row = '0;
    item.col = '0;
    item.value = '0;
    item.weight = '0;
    result.ready = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Fill the whole factor and the vector so that no later read or update
    // ever touches an entry that was never written.
    for (int i = 0; i < DIM; i++) begin
      for (int j = 0; j < DIM; j++) begin
        put(OP_LOAD_F, i, j, (i == j) ? 32'sh0001_0000 : ($signed($urandom_range(65536)) - 32768),
            $urandom());
      end
      put(OP_LOAD_X, i, $urandom_range(63), $signed($urandom_range(131072)) - 65536, 0);
    end

    // Directed cases: a plain update, a downdate, extremes, range errors,
    // a zero pivot, a negative radicand and a zero divisor.
    put(OP_UPDATE, 63, 63, Q_MIN, 32'sh0001_0000);
    put(OP_READ, 0, 0, 0, 0);
    put(OP_READ, 0, DIM - 1, 0, 0);
    put(OP_UPDATE, 0, 0, 0, 32'shFFFF_C000);
    put(OP_READ, 1, 1, 0, 0);
    put(OP_LOAD_F, DIM - 1, 0, Q_MAX, 0);
    put(OP_READ, DIM - 1, 0, 0, 0);
    put(OP_LOAD_F, 3, 7, Q_MIN, 0);
    put(OP_READ, 3, 7, 0, 0);
    put(OP_LOAD_F, 63, 0, 1, 0);
    put(OP_LOAD_F, 0, 63, 1, 0);
    put(OP_READ, 63, 63, 0, 0);
    put(OP_READ, DIM, 0, 0, 0);
    put(OP_LOAD_X, DIM, 0, 5, 0);
    put(OP_LOAD_X, 63, 63, -1, 0);
    // Zero pivot on the first diagonal entry.
    put(OP_LOAD_F, 0, 0, 0, 0);
    put(OP_UPDATE, 0, 0, 0, 32'sh0001_0000);
    // A tiny pivot with a zero vector element makes r, and thus c, zero.
    put(OP_LOAD_F, 0, 0, 1, 0);
    put(OP_LOAD_X, 0, 0, 0, 0);
    put(OP_UPDATE, 0, 0, 0, 32'sh0002_0000);
    put(OP_READ, 0, 1, 0, 0);
    // Huge negative weight drives the radicand below zero.
    put(OP_LOAD_F, 0, 0, 32'sh0001_0000, 0);
    put(OP_LOAD_X, 0, 0, 32'sh0001_0000, 0);
    put(OP_UPDATE, 0, 0, 0, Q_MIN);
    put(OP_UPDATE, 0, 0, 0, Q_MAX);

    while (sent < ITEM_GOAL) begin
      kind = $urandom_range(99);
      if (kind < 8) begin
        // Well-formed sequence: fresh pivots and vector, an update, read-backs.
        n = $urandom_range(6, 2);
        for (int i = 0; i < n; i++) begin
          k = $urandom_range(DIM - 1);
          put(OP_LOAD_F, k, k, pivot_value(), 0);
          put(OP_LOAD_X, $urandom_range(DIM - 1), 0, $signed($urandom_range(262144)) - 131072,
              0);
        end
        put(OP_UPDATE, $urandom_range(63), $urandom_range(63), $urandom(),
            ($urandom_range(3) == 0) ? $urandom() : ($signed($urandom_range(262144)) - 98304));
        put(OP_READ, $urandom_range(DIM - 1), $urandom_range(DIM - 1), 0, 0);
        put(OP_READ, 0, $urandom_range(DIM - 1), 0, 0);
      end else if (kind < 11) begin
        put(OP_UPDATE, $urandom_range(63), $urandom_range(63), $urandom(), $urandom());
      end else if (kind < 45) begin
        put(OP_LOAD_F, $urandom_range(DIM - 1), $urandom_range(DIM - 1), any_value(),
            $urandom());
      end else if (kind < 60) begin
        put(OP_LOAD_X, $urandom_range(DIM - 1), $urandom_range(63), any_value(), $urandom());
      end else if (kind < 88) begin
        put(OP_READ, $urandom_range(DIM - 1), $urandom_range(DIM - 1), $urandom(), $urandom());
      end else begin
        // Out-of-range indices on any of the three indexed operations.
        put(($urandom_range(2) == 0) ? OP_LOAD_X : (($urandom_range(1) == 0) ? OP_LOAD_F
            : OP_READ), $urandom_range(63, DIM), $urandom_range(63), $urandom(), $urandom());
      end
    end

    @(negedge clk);
    item.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (failures == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule

// File: files.f
sv/chol_pkg.sv
sv/chol_if.sv
sv/chol_ram.sv
sv/chol_unit.sv
sv/chol_ctrl.sv
sv/chol_dp.sv
sv/cholesky_weighted_rank_one_update.sv
sv/chol_checker.sv
tb/sv/chol_update_checker.sv
tb/sv/tb.sv
